// ===== hdl/spsq_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and codes of the stable sorted priority queue
package spsq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OCC_W    = 5;

   localparam logic [1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [1:0] ACT_DEQUEUE = 2'd1;
   localparam logic [1:0] ACT_PEEK    = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [63:0] name_head;
      logic [63:0] name_middle;
      logic [31:0] name_tail;
      logic [7:0]  age;
      logic [15:0] prio;
   } entry_type;

   typedef struct packed {
      logic load;
      logic shift;
   } ctrl_type;

endpackage

// ===== hdl/spsq_cell.sv =====
`timescale 1ns / 1ps
// one slot of the sorted chain: keep, take the new word, or take a neighbor
module spsq_cell (
   input  logic                clock,
   input  spsq_pkg::ctrl_type  ctrl,
   input  spsq_pkg::entry_type new_entry,
   input  spsq_pkg::entry_type left_entry,
   input  spsq_pkg::entry_type right_entry,
   input  logic                occupied,
   input  logic                left_stays,
   output spsq_pkg::entry_type entry,
   output logic                stays
);

   spsq_pkg::entry_type entry_ff;
   spsq_pkg::entry_type entry_in;

   assign stays = occupied && (entry_ff.prio <= new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.shift) begin
         entry_in = right_entry;
      end else if (ctrl.load && !stays) begin
         entry_in = left_stays ? new_entry : left_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hdl/stable_sorted_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// Stable sorted priority queue built as a chain of slot cells, slot 0 the head.
// busy is always low: one command is taken every clock cycle, and its result
// appears with rsp_strobe in the cycle after start, since every cell compares
// its priority with the new word in parallel and shifts in a single step.
// Results cannot be held off, so the receiver must take each one when it shows.
module stable_sorted_priority_queue_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_name_head,
   input  logic [63:0] req_name_middle,
   input  logic [31:0] req_name_tail,
   input  logic [7:0]  req_entry_age,
   input  logic [15:0] req_entry_priority,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic        rsp_entry_valid,
   output logic [63:0] rsp_out_name_head,
   output logic [63:0] rsp_out_name_middle,
   output logic [31:0] rsp_out_name_tail,
   output logic [7:0]  rsp_out_age,
   output logic [15:0] rsp_out_priority,
   output logic [4:0]  rsp_occupancy
);

   localparam int CAP = spsq_pkg::CAPACITY;

   logic [spsq_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       rsp_strobe_ff;
   logic [1:0]                 status_ff, status_in;
   logic                       valid_ff, valid_in;
   spsq_pkg::entry_type        out_ff, out_in;
   logic [spsq_pkg::OCC_W-1:0] occ_ff;

   spsq_pkg::entry_type new_entry;
   spsq_pkg::ctrl_type  ctrl;
   spsq_pkg::entry_type cell_entry [CAP];
   logic                cell_stays [CAP];
   logic                accept, full, empty;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == spsq_pkg::CNT_W'(CAP));
   assign empty  = (count_ff == '0);

   assign new_entry.name_head   = req_name_head;
   assign new_entry.name_middle = req_name_middle;
   assign new_entry.name_tail   = req_name_tail;
   assign new_entry.age         = req_entry_age;
   assign new_entry.prio        = req_entry_priority;

   assign ctrl.load  = accept && (req_action == spsq_pkg::ACT_ENQUEUE) && !full;
   assign ctrl.shift = accept && (req_action == spsq_pkg::ACT_DEQUEUE) && !empty;

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      spsq_pkg::entry_type left_e, right_e;
      logic                left_s;
      if (i == 0) begin : g_first
         assign left_e = new_entry;
         assign left_s = 1'b1;
      end else begin : g_inner
         assign left_e = cell_entry[i-1];
         assign left_s = cell_stays[i-1];
      end
      if (i == CAP - 1) begin : g_last
         assign right_e = cell_entry[i];
      end else begin : g_mid
         assign right_e = cell_entry[i+1];
      end
      spsq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_entry  (left_e),
         .right_entry (right_e),
         .occupied    (spsq_pkg::CNT_W'(i) < count_ff),
         .left_stays  (left_s),
         .entry       (cell_entry[i]),
         .stays       (cell_stays[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status_in = spsq_pkg::STATUS_OK;
      valid_in  = 1'b0;
      out_in    = '0;
      unique case (req_action)
         spsq_pkg::ACT_ENQUEUE: begin
            if (full) begin
               status_in = spsq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + spsq_pkg::CNT_W'(1);
            end
         end
         spsq_pkg::ACT_DEQUEUE, spsq_pkg::ACT_PEEK: begin
            if (empty) begin
               status_in = spsq_pkg::STATUS_EMPTY;
            end else begin
               valid_in = 1'b1;
               out_in   = cell_entry[0];
               if (req_action == spsq_pkg::ACT_DEQUEUE) begin
                  count_in = count_ff - spsq_pkg::CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         valid_ff  <= valid_in;
         out_ff    <= out_in;
         occ_ff    <= spsq_pkg::OCC_W'(count_in);
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = status_ff;
   assign rsp_entry_valid     = valid_ff;
   assign rsp_out_name_head   = out_ff.name_head;
   assign rsp_out_name_middle = out_ff.name_middle;
   assign rsp_out_name_tail   = out_ff.name_tail;
   assign rsp_out_age         = out_ff.age;
   assign rsp_out_priority    = out_ff.prio;
   assign rsp_occupancy       = occ_ff;

   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(start)) else $error("result word without a command");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spsq_pkg::CNT_W'(CAP)) else $error("entry count beyond capacity");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && status_ff == spsq_pkg::STATUS_FULL |-> count_ff == spsq_pkg::CNT_W'(CAP))
      else $error("full status while not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && status_ff == spsq_pkg::STATUS_EMPTY |-> count_ff == '0)
      else $error("empty status while entries held");

   a_valid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && valid_ff |-> status_ff == spsq_pkg::STATUS_OK)
      else $error("entry word returned with error status");

endmodule
